// ===== hdl/bitmap_missing_value_finder_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap missing value finder
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BITMAP_MISSING_VALUE_FINDER_CORE_MACROS_SVH
`define BITMAP_MISSING_VALUE_FINDER_CORE_MACROS_SVH

// The condition holds at every clock edge.
`define BMVF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BMVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bmvf_pkg.sv =====
// ---------------------------------------------------------------------------
// Bitmap missing value finder package
// Fixed field widths, register indexes and the controller/datapath structs.
// ---------------------------------------------------------------------------
package bmvf_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 2'd1;

  localparam logic [VALUE_W-1:0] RESET_BASE  = 32'd0;
  localparam logic [CNT_W-1:0]   RESET_COUNT = 17'd65536;

  localparam logic MODE_MARK = 1'b0;
  localparam logic MODE_FIND = 1'b1;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic mark_rd;
    logic mark_wr;
    logic scan_rd;
    logic find_chk;
    logic load_out;
  } bmvf_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mode;
    logic oor;
    logic cnt_zero;
    logic word_free;
    logic scan_last;
  } bmvf_sts_t;

endpackage

// ===== hdl/bmvf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Bitmap missing value finder controller
// Sequences the clearing pass, mark read-modify-write and the find scan.
// ---------------------------------------------------------------------------
module bmvf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bmvf_pkg::bmvf_sts_t sts_i,
  output bmvf_pkg::bmvf_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_MRD    = 3'd3;
  localparam logic [2:0] ST_MWR    = 3'd4;
  localparam logic [2:0] ST_FRD    = 3'd5;
  localparam logic [2:0] ST_FCHK   = 3'd6;
  localparam logic [2:0] ST_RESP   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.mode == bmvf_pkg::MODE_MARK) begin
          state_d = sts_i.oor ? ST_RESP : ST_MRD;
        end else begin
          state_d = sts_i.cnt_zero ? ST_RESP : ST_FRD;
        end
      end
      ST_MRD: begin
        cmd_o.mark_rd = 1'b1;
        state_d       = ST_MWR;
      end
      ST_MWR: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = ST_RESP;
      end
      ST_FRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_FCHK;
      end
      ST_FCHK: begin
        cmd_o.find_chk = 1'b1;
        // A word with a clear bit, or the last word of the range, ends the scan.
        if (sts_i.word_free || sts_i.scan_last) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_FRD;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/bmvf_dpath.sv =====
// ---------------------------------------------------------------------------
// Bitmap missing value finder datapath
// Configuration registers, presence bitmap memory, scan logic and result word.
// ---------------------------------------------------------------------------
module bmvf_dpath #(
  parameter int unsigned CAPACITY  = 65536,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [bmvf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bmvf_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic                                 mode_i,
  input  logic [bmvf_pkg::VALUE_W-1:0]         value_i,
  input  bmvf_pkg::bmvf_cmd_t                  cmd_i,
  output bmvf_pkg::bmvf_sts_t                  sts_o,
  output logic                                 found_o,
  output logic [bmvf_pkg::VALUE_W-1:0]         missing_value_o,
  output logic                                 out_of_range_o
);

  localparam int unsigned WB_LG  = $clog2(WORD_BITS);
  localparam int unsigned OFF_W  = $clog2(CAPACITY);
  localparam int unsigned WORDS  = CAPACITY / WORD_BITS;
  localparam int unsigned ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned VW     = bmvf_pkg::VALUE_W;
  localparam int unsigned CW     = bmvf_pkg::CNT_W;
  localparam logic [VW-1:0] CAP_V = VW'(CAPACITY);

  logic [VW-1:0]        base_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        eff_cnt;
  logic [VW-1:0]        eff_cnt_v;
  logic [VW-1:0]        diff;
  logic                 in_range;

  logic                 mode_q;
  logic [OFF_W-1:0]     mark_off_q;
  logic [ADDR_W-1:0]    mark_addr;
  logic [WORD_BITS-1:0] mark_bit;
  logic [ADDR_W-1:0]    clr_q;
  logic [ADDR_W-1:0]    scan_q;
  logic [ADDR_W-1:0]    scan_last_addr;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic                 mem_re;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_ra;
  logic [ADDR_W-1:0]    mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  logic [WORD_BITS-1:0] free_bits;
  logic [WB_LG-1:0]     free_idx;
  logic [VW-1:0]        find_off;
  logic                 hit;

  logic                 res_found_q;
  logic [VW-1:0]        res_value_q;
  logic                 res_oor_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= bmvf_pkg::RESET_BASE;
      count_q <= bmvf_pkg::RESET_COUNT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bmvf_pkg::CFG_RANGE_BASE:  base_q  <= cfg_data_i;
        bmvf_pkg::CFG_RANGE_COUNT: count_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // A count above the bitmap size saturates to the bitmap size.
  assign eff_cnt   = ({{(VW-CW){1'b0}}, count_q} > CAP_V) ? CW'(CAP_V) : count_q;
  assign eff_cnt_v = {{(VW-CW){1'b0}}, eff_cnt};
  assign diff      = value_i - base_q;
  assign in_range  = diff < eff_cnt_v;

  assign scan_last_addr = ADDR_W'((eff_cnt_v - VW'(1)) >> WB_LG);
  assign mark_addr      = ADDR_W'(mark_off_q >> WB_LG);
  assign mark_bit       = WORD_BITS'(1) << mark_off_q[WB_LG-1:0];

  assign free_bits = ~rd_q;

  always_comb begin
    free_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_idx = WB_LG'(i);
      end
    end
  end

  assign find_off = (VW'(scan_q) << WB_LG) | VW'(free_idx);
  assign hit      = (|free_bits) && (find_off < eff_cnt_v);

  always_comb begin
    mem_re = cmd_i.mark_rd || cmd_i.scan_rd;
    mem_ra = cmd_i.mark_rd ? mark_addr : scan_q;
    mem_we = 1'b0;
    mem_wa = scan_q;
    mem_wd = rd_q | (WORD_BITS'(1) << free_idx);
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (cmd_i.mark_wr) begin
      mem_we = 1'b1;
      mem_wa = mark_addr;
      mem_wd = rd_q | mark_bit;
    end else if (cmd_i.find_chk && hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      scan_q <= '0;
      mode_q <= bmvf_pkg::MODE_MARK;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.accept) begin
        mode_q <= mode_i;
        scan_q <= '0;
      end else if (cmd_i.find_chk) begin
        scan_q <= scan_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mark_off_q  <= OFF_W'(diff);
      res_found_q <= 1'b0;
      res_value_q <= '0;
      res_oor_q   <= (mode_i == bmvf_pkg::MODE_MARK) && !in_range;
    end else if (cmd_i.find_chk && hit) begin
      res_found_q <= 1'b1;
      res_value_q <= base_q + find_off;
    end
    if (cmd_i.load_out) begin
      found_o         <= res_found_q;
      missing_value_o <= res_value_q;
      out_of_range_o  <= res_oor_q;
    end
  end

  assign sts_o.clr_done  = (clr_q == ADDR_W'(WORDS - 1));
  assign sts_o.mode      = mode_q;
  assign sts_o.oor       = res_oor_q;
  assign sts_o.cnt_zero  = (eff_cnt == '0);
  assign sts_o.word_free = |free_bits;
  assign sts_o.scan_last = (scan_q == scan_last_addr);

endmodule

// ===== hdl/bitmap_missing_value_finder_core.sv =====
// ---------------------------------------------------------------------------
// Bitmap missing value finder core
// Presence bitmap over a configured range with mark and find-first-clear.
// ---------------------------------------------------------------------------
// After reset the block clears its bitmap memory, one word of WORD_BITS bits
// per cycle, and takes no word until that pass is done; configuration writes
// are taken at any time. After a mark word is accepted, decode, memory read,
// write-back and the result load follow. A mark outside the range skips the
// memory read and write-back. A find word is decoded and then scans bitmap
// words from the bottom of the range, each word read through the single read
// port and then tested, before the result load. One word is worked on at a
// time; a finished result waits in the output register while the next word is
// accepted, and the next result then holds the block in its last cycle until
// the waiting one is taken.
// WORD_BITS must be a power of two that divides CAPACITY.
module bitmap_missing_value_finder_core #(
  parameter int unsigned CAPACITY  = 65536,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bmvf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bmvf_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [bmvf_pkg::VALUE_W-1:0]      value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [bmvf_pkg::VALUE_W-1:0]      missing_value_o,
  output logic                              out_of_range_o
);

`include "bitmap_missing_value_finder_core_macros.svh"

  bmvf_pkg::bmvf_cmd_t cmd;
  bmvf_pkg::bmvf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bmvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmvf_dpath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .found_o         (found_o),
    .missing_value_o (missing_value_o),
    .out_of_range_o  (out_of_range_o)
  );

  // A result is either a find or a mark outcome, never both.
  `BMVF_ASSERT_IMP(a_found_excl_oor, out_valid_o, !(found_o && out_of_range_o), "found and out_of_range both set")
  // A find that missed returns a zero value.
  `BMVF_ASSERT_IMP(a_miss_zero, out_valid_o && !found_o, missing_value_o == '0, "nonzero value without found")
  // Only one word is in flight: acceptance closes the input until it is done.
  `BMVF_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "input reopened right after accept")

endmodule
